[hdl/lz_control_byte_decompressor_unit_macros.svh]
// Assertion macros for the control-byte LZ decompressor.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef LZ_CONTROL_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZ_CONTROL_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH

// Implication checked on the same edge.
`define LZCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the following edge.
`define LZCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lzcd_pkg.sv]
// Shared constants and controller/datapath interface types for the
// control-byte LZ decompressor. No dependencies.
`default_nettype none
package lzcd_pkg;

  localparam int unsigned WindowDepth    = 4096;
  localparam int unsigned WinAw          = $clog2(WindowDepth);
  localparam int unsigned BytesPerResult = 8;
  localparam int unsigned SizeW          = 24;
  localparam int unsigned LenW           = 9;
  localparam int unsigned CntW           = 4;
  localparam int unsigned CfgIdxW        = 2;

  localparam logic [CfgIdxW-1:0] RegRawSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCheck   = 2'd1;

  localparam logic [1:0] StRunning    = 2'd0;
  localparam logic [1:0] StOk         = 2'd1;
  localparam logic [1:0] StCorrupt    = 2'd2;
  localparam logic [1:0] StIncomplete = 2'd3;

  localparam logic [3:0] LenMask  = 4'hf;
  localparam logic [8:0] LenBias  = 9'd3;
  localparam logic [8:0] LenLong  = 9'd18;

  typedef struct packed {
    logic       latch_in;
    logic       load_flags;
    logic       load_tag0;
    logic       load_tag1;
    logic       add_len;
    logic       next_flag;
    logic       set_err;
    logic       load_remain;
    logic       push_lit;
    logic       mem_rd;
    logic       push_rd;
    logic       emit;
    logic       emit_final;
    logic [1:0] status;
    logic       clear_stream;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic flag0;
    logic flags_last;
    logic len_long;
    logic off_bad;
    logic remain_zero;
    logic pack_full;
    logic out_free;
    logic err;
    logic size_mismatch;
    logic check;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

[hdl/lzcd_datapath.sv]
// Datapath: stream registers, 4096-byte history memory, result packing
// and the output register. Depends on lzcd_pkg.
`default_nettype none
module lzcd_datapath #(
  parameter int unsigned BYTES_PER_RESULT = lzcd_pkg::BytesPerResult
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lzcd_pkg::cmd_t               cmd_i,
  output lzcd_pkg::sts_t                    sts_o,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         last_byte_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [lzcd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [lzcd_pkg::SizeW-1:0]   cfg_data_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic [7:0]                        out_bytes_o [8],
  output logic [lzcd_pkg::CntW-1:0]         byte_count_o,
  output logic                              run_end_o,
  output logic [1:0]                        status_o,
  output logic [lzcd_pkg::SizeW-1:0]        total_length_o
);
  import lzcd_pkg::*;

  logic [7:0]       byte_q;
  logic             last_q;
  logic [7:0]       flag_bits_q;
  logic [3:0]       flags_left_q;
  logic [LenW-1:0]  tag_len_q;
  logic [WinAw-1:0] tag_off_q;
  logic [SizeW-1:0] produced_q;
  logic             err_q;
  logic [LenW-1:0]  remain_q;
  logic [SizeW-1:0] raw_q;
  logic             chk_q;
  logic [7:0]       pack_q [8];
  logic [CntW-1:0]  pack_cnt_q;
  logic [7:0]       rd_data_q;
  logic [7:0]       out_q [8];
  logic [CntW-1:0]  out_cnt_q;
  logic             out_valid_q, out_end_q;
  logic [1:0]       out_st_q;
  logic [SizeW-1:0] out_total_q;
  logic [7:0]       mem [WindowDepth];

  logic [SizeW-1:0] room;
  logic             push;
  logic [7:0]       push_data;
  logic [WinAw-1:0] rd_addr;

  assign room      = (raw_q > produced_q) ? raw_q - produced_q : '0;
  assign push      = cmd_i.push_lit | cmd_i.push_rd;
  assign push_data = cmd_i.push_lit ? byte_q : rd_data_q;
  assign rd_addr   = produced_q[WinAw-1:0] - tag_off_q;

  always_comb begin
    sts_o.full          = produced_q >= raw_q;
    sts_o.flag0         = flag_bits_q[0];
    sts_o.flags_last    = flags_left_q <= 4'd1;
    sts_o.len_long      = tag_len_q == LenLong;
    sts_o.off_bad       = (tag_off_q == '0) ||
                          ({{(SizeW-WinAw){1'b0}}, tag_off_q} > produced_q);
    sts_o.remain_zero   = remain_q == '0;
    sts_o.pack_full     = pack_cnt_q == CntW'(BYTES_PER_RESULT);
    sts_o.out_free      = !out_valid_q || !out_stall_i;
    sts_o.err           = err_q;
    sts_o.size_mismatch = produced_q != raw_q;
    sts_o.check         = chk_q;
    sts_o.last          = last_q;
  end

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[produced_q[WinAw-1:0]] <= push_data;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      byte_q <= in_byte_i;
      last_q <= last_byte_i;
    end
    if (cmd_i.emit) begin
      out_q       <= pack_q;
      out_cnt_q   <= pack_cnt_q;
      out_end_q   <= cmd_i.emit_final;
      out_st_q    <= cmd_i.status;
      out_total_q <= produced_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      tag_len_q    <= '0;
      tag_off_q    <= '0;
      produced_q   <= '0;
      err_q        <= 1'b0;
      remain_q     <= '0;
      raw_q        <= '0;
      chk_q        <= 1'b0;
      pack_q       <= '{default: '0};
      pack_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == RegRawSize) begin
        raw_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == RegCheck) begin
        chk_q <= cfg_data_i[0];
      end
      if (cmd_i.load_flags) begin
        flag_bits_q  <= byte_q;
        flags_left_q <= 4'd8;
      end
      if (cmd_i.next_flag) begin
        flag_bits_q <= flag_bits_q >> 1;
        if (flags_left_q != '0) begin
          flags_left_q <= flags_left_q - 4'd1;
        end
      end
      if (cmd_i.load_tag0) begin
        tag_len_q <= {5'd0, byte_q[3:0] & LenMask} + LenBias;
        tag_off_q <= {byte_q[7:4], 8'h00};
      end
      if (cmd_i.load_tag1) begin
        tag_off_q[7:0] <= byte_q;
      end
      if (cmd_i.add_len) begin
        tag_len_q <= tag_len_q + {1'b0, byte_q};
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.load_remain) begin
        remain_q <= (room < {{(SizeW-LenW){1'b0}}, tag_len_q}) ? room[LenW-1:0]
                                                                 : tag_len_q;
      end else if (cmd_i.push_rd) begin
        remain_q <= remain_q - 9'd1;
      end
      // Bytes past the count of a result must read as zero.
      if (push) begin
        pack_q[pack_cnt_q[2:0]] <= push_data;
      end else if (cmd_i.emit) begin
        pack_q <= '{default: '0};
      end
      if (push) begin
        produced_q <= produced_q + 24'd1;
        pack_cnt_q <= pack_cnt_q + 4'd1;
      end else if (cmd_i.emit) begin
        pack_cnt_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // A new stream starts once its final result has been handed over.
      if (cmd_i.clear_stream) begin
        flag_bits_q  <= '0;
        flags_left_q <= '0;
        tag_len_q    <= '0;
        tag_off_q    <= '0;
        produced_q   <= '0;
        err_q        <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_bytes_o    = out_q;
  assign byte_count_o   = out_cnt_q;
  assign run_end_o      = out_end_q;
  assign status_o       = out_st_q;
  assign total_length_o = out_total_q;

endmodule
`default_nettype wire

[hdl/lzcd_ctrl.sv]
// Controller: decode phase and per-transaction sequencing of the datapath.
// Depends on lzcd_pkg.
`default_nettype none
module lzcd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lzcd_pkg::sts_t sts_i,
  output lzcd_pkg::cmd_t      cmd_o
);
  import lzcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MCHK, S_MRD, S_MWR, S_FLUSH, S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    PH_CONTROL, PH_ITEM, PH_TAG1, PH_TAG2, PH_SURPLUS
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  phase_e after_flag;
  logic   corrupt;

  assign in_stall_o = state_q != S_IDLE;
  assign after_flag = sts_i.flags_last ? PH_CONTROL : PH_ITEM;
  assign corrupt    = sts_i.err || phase_q == PH_TAG1 || phase_q == PH_TAG2;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.latch_in = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        if (!sts_i.err) begin
          case (phase_q)
            PH_CONTROL: begin
              if (sts_i.full) begin
                phase_d = PH_SURPLUS;
              end else begin
                cmd_o.load_flags = 1'b1;
                phase_d = PH_ITEM;
              end
            end
            PH_ITEM: begin
              if (sts_i.full) begin
                phase_d = PH_SURPLUS;
              end else if (sts_i.flag0) begin
                cmd_o.load_tag0 = 1'b1;
                phase_d = PH_TAG1;
              end else begin
                cmd_o.push_lit  = 1'b1;
                cmd_o.next_flag = 1'b1;
                phase_d = after_flag;
              end
            end
            PH_TAG1: begin
              cmd_o.load_tag1 = 1'b1;
              if (sts_i.len_long) begin
                phase_d = PH_TAG2;
              end else begin
                state_d = S_MCHK;
              end
            end
            PH_TAG2: begin
              cmd_o.add_len = 1'b1;
              state_d = S_MCHK;
            end
            default: phase_d = PH_SURPLUS;
          endcase
        end
      end
      S_MCHK: begin
        if (sts_i.off_bad) begin
          cmd_o.set_err = 1'b1;
          state_d = S_FINISH;
        end else begin
          cmd_o.load_remain = 1'b1;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        if (sts_i.remain_zero) begin
          cmd_o.next_flag = 1'b1;
          phase_d = after_flag;
          state_d = S_FINISH;
        end else if (sts_i.pack_full) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = S_MWR;
        end
      end
      S_MWR: begin
        cmd_o.push_rd = 1'b1;
        state_d = S_MRD;
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_MRD;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_final = 1'b1;
          if (sts_i.last) begin
            if (corrupt) begin
              cmd_o.status = StCorrupt;
            end else if (sts_i.check && (sts_i.size_mismatch || phase_q == PH_SURPLUS)) begin
              cmd_o.status = StIncomplete;
            end else begin
              cmd_o.status = StOk;
            end
            cmd_o.clear_stream = 1'b1;
            phase_d = PH_CONTROL;
          end else begin
            cmd_o.status = StRunning;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_CONTROL;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

[hdl/lz_control_byte_decompressor_unit.sv]
// A result is registered once its input transaction has been accepted and passed
// decode and finish; no new input is taken until the unit is back in idle.
// A byte completing a match also passes the match check, then per copied byte a
// registered history read and a write, plus a flush per full result issued before
// the last; stalls add on. Reset (asynchronous, active low) clears control state
// and most registers; history memory is not cleared and needs no clearing pass.
`default_nettype none
module lz_control_byte_decompressor_unit #(
  parameter int unsigned BYTES_PER_RESULT = lzcd_pkg::BytesPerResult
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         last_byte_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lzcd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [lzcd_pkg::SizeW-1:0]   cfg_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        out_byte0_o,
  output logic [7:0]                        out_byte1_o,
  output logic [7:0]                        out_byte2_o,
  output logic [7:0]                        out_byte3_o,
  output logic [7:0]                        out_byte4_o,
  output logic [7:0]                        out_byte5_o,
  output logic [7:0]                        out_byte6_o,
  output logic [7:0]                        out_byte7_o,
  output logic [lzcd_pkg::CntW-1:0]         byte_count_o,
  output logic                              run_end_o,
  output logic [1:0]                        status_o,
  output logic [lzcd_pkg::SizeW-1:0]        total_length_o
);
  import lzcd_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] out_bytes [8];

  assign cfg_ready_o = 1'b1;

  lzcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzcd_datapath #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_byte_i      (in_byte_i),
    .last_byte_i    (last_byte_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_bytes_o    (out_bytes),
    .byte_count_o   (byte_count_o),
    .run_end_o      (run_end_o),
    .status_o       (status_o),
    .total_length_o (total_length_o)
  );

  assign out_byte0_o = out_bytes[0];
  assign out_byte1_o = out_bytes[1];
  assign out_byte2_o = out_bytes[2];
  assign out_byte3_o = out_bytes[3];
  assign out_byte4_o = out_bytes[4];
  assign out_byte5_o = out_bytes[5];
  assign out_byte6_o = out_bytes[6];
  assign out_byte7_o = out_bytes[7];

`include "lz_control_byte_decompressor_unit_macros.svh"

  // A result never carries more bytes than one result may hold.
  `LZCD_ASSERT_NOW(a_count_range, out_valid_o,
                   byte_count_o <= CntW'(BYTES_PER_RESULT), "result byte count too large")
  // Only the closing result of an input byte may report a final status.
  `LZCD_ASSERT_NOW(a_status_final, out_valid_o && !run_end_o,
                   status_o == StRunning, "status on a non-final result")
  // Once an input transaction is taken the unit is busy until its result is issued.
  `LZCD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o,
                    in_stall_o, "input taken while still decoding")

endmodule
`default_nettype wire
